[sv/dcsp_pkg.sv]
// Package for the delta command stream parser: codes, record types, magic table.
`default_nettype none
package dcsp_pkg;

  localparam int CHECKSUM_BYTES_DEF = 8;
  localparam int QDEPTH = 4;
  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_COPY    = 3'd1;
  localparam logic [2:0] KIND_ADD_HDR = 3'd2;
  localparam logic [2:0] KIND_ADD_DAT = 3'd3;
  localparam logic [2:0] KIND_END_OK  = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_BAD_HEADER  = 4'd1;
  localparam logic [3:0] ERR_TRUNC_COPY  = 4'd2;
  localparam logic [3:0] ERR_TRUNC_ADD   = 4'd3;
  localparam logic [3:0] ERR_TRUNC_DATA  = 4'd4;
  localparam logic [3:0] ERR_COPY_RANGE  = 4'd5;
  localparam logic [3:0] ERR_ADD_RANGE   = 4'd6;
  localparam logic [3:0] ERR_TRAILING    = 4'd7;
  localparam logic [3:0] ERR_MISSING_END = 4'd8;
  localparam logic [3:0] ERR_UNKNOWN_OP  = 4'd9;

  localparam logic [7:0] OP_END  = 8'd0;
  localparam logic [7:0] OP_COPY = 8'd1;
  localparam logic [7:0] OP_ADD  = 8'd2;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_FLAGS,
    PH_VSIZE,
    PH_SRCSUM,
    PH_DSTSUM,
    PH_OPCODE,
    PH_COPY,
    PH_ADDARGS,
    PH_ADDDATA,
    PH_DISCARD
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  flags_byte;
    logic [31:0] target_size;
    logic [63:0] source_checksum;
    logic [63:0] target_checksum;
    logic [31:0] src_offset;
    logic [31:0] dst_offset;
    logic [31:0] run_length;
    logic [7:0]  data_byte;
    logic [3:0]  error_code;
    logic        last_of_run;
  } rec_t;

  // Records caused by one byte: an optional main record, then an optional error.
  typedef struct packed {
    logic       has_main;
    rec_t       main;
    logic       has_err;
    logic [3:0] err_code;
  } parse_res_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h44;
      2'd1:    b = 8'h4C;
      2'd2:    b = 8'h54;
      default: b = 8'h03;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[sv/dcsp_parse.sv]
// Parser state and per-byte decode for the delta command stream.
`default_nettype none
module dcsp_parse #(
  parameter int CHECKSUM_BYTES = dcsp_pkg::CHECKSUM_BYTES_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  wire [7:0]            byte_in,
  input  wire                  last_byte,
  output dcsp_pkg::parse_res_t res
);
  import dcsp_pkg::*;

  phase_t      phase, phase_next;
  logic [4:0]  cnt, cnt_next;
  logic [63:0] sw, sw_next;
  logic [31:0] vsize, vsize_next;
  logic [31:0] src, src_next;
  logic [31:0] dst, dst_next;
  logic [31:0] rem, rem_next;
  logic [7:0]  hflags, hflags_next;
  logic [63:0] ssum, ssum_next;

  logic [63:0] take_sw;
  logic [4:0]  take_cnt;
  logic [31:0] len;
  logic [31:0] rem_dec;
  logic        range_ok;
  logic        err_fire;
  logic [3:0]  err_code;
  logic        cmd_done;

  assign take_sw  = {sw[55:0], byte_in};
  assign take_cnt = cnt + 5'd1;
  assign len      = take_sw[31:0];
  assign range_ok = (dst <= vsize) && (len <= vsize - dst);
  assign rem_dec  = (rem != 32'd0) ? rem - 32'd1 : rem;

  always_comb begin
    phase_next  = phase;
    cnt_next    = cnt;
    sw_next     = sw;
    vsize_next  = vsize;
    src_next    = src;
    dst_next    = dst;
    rem_next    = rem;
    hflags_next = hflags;
    ssum_next   = ssum;
    res         = '0;
    err_fire    = 1'b0;
    err_code    = ERR_NONE;
    cmd_done    = 1'b0;

    case (phase)
      PH_MAGIC: begin
        if (byte_in != magic_byte(cnt[1:0])) begin
          err_fire = 1'b1;
          err_code = ERR_BAD_HEADER;
        end else begin
          cnt_next = take_cnt;
          if (take_cnt >= 5'd4) begin
            phase_next = PH_FLAGS;
            cnt_next   = '0;
            sw_next    = '0;
          end
          if (last_byte) begin
            err_fire = 1'b1;
            err_code = ERR_BAD_HEADER;
          end
        end
      end
      PH_FLAGS: begin
        hflags_next = byte_in;
        phase_next  = PH_VSIZE;
        cnt_next    = '0;
        sw_next     = '0;
        if (last_byte) begin
          err_fire = 1'b1;
          err_code = ERR_BAD_HEADER;
        end
      end
      PH_VSIZE: begin
        sw_next  = take_sw;
        cnt_next = take_cnt;
        if (take_cnt >= 5'd4) begin
          vsize_next = take_sw[31:0];
          phase_next = PH_SRCSUM;
          cnt_next   = '0;
          sw_next    = '0;
        end
        if (last_byte) begin
          err_fire = 1'b1;
          err_code = ERR_BAD_HEADER;
        end
      end
      PH_SRCSUM: begin
        sw_next  = take_sw;
        cnt_next = take_cnt;
        if (take_cnt >= 5'(CHECKSUM_BYTES)) begin
          ssum_next  = take_sw;
          phase_next = PH_DSTSUM;
          cnt_next   = '0;
          sw_next    = '0;
        end
        if (last_byte) begin
          err_fire = 1'b1;
          err_code = ERR_BAD_HEADER;
        end
      end
      PH_DSTSUM: begin
        sw_next  = take_sw;
        cnt_next = take_cnt;
        if (take_cnt >= 5'(CHECKSUM_BYTES)) begin
          res.has_main             = 1'b1;
          res.main.kind            = KIND_HEADER;
          res.main.flags_byte      = hflags;
          res.main.target_size     = vsize;
          res.main.source_checksum = ssum;
          res.main.target_checksum = take_sw;
          cmd_done                 = 1'b1;
        end else if (last_byte) begin
          err_fire = 1'b1;
          err_code = ERR_BAD_HEADER;
        end
      end
      PH_OPCODE: begin
        if (byte_in == OP_END) begin
          if (last_byte) begin
            res.has_main  = 1'b1;
            res.main.kind = KIND_END_OK;
            phase_next    = PH_MAGIC;
            cnt_next      = '0;
            sw_next       = '0;
          end else begin
            err_fire = 1'b1;
            err_code = ERR_TRAILING;
          end
        end else if (byte_in == OP_COPY) begin
          phase_next = PH_COPY;
          cnt_next   = '0;
          sw_next    = '0;
          if (last_byte) begin
            err_fire = 1'b1;
            err_code = ERR_TRUNC_COPY;
          end
        end else if (byte_in == OP_ADD) begin
          phase_next = PH_ADDARGS;
          cnt_next   = '0;
          sw_next    = '0;
          if (last_byte) begin
            err_fire = 1'b1;
            err_code = ERR_TRUNC_ADD;
          end
        end else begin
          err_fire = 1'b1;
          err_code = ERR_UNKNOWN_OP;
        end
      end
      PH_COPY: begin
        sw_next  = take_sw;
        cnt_next = take_cnt;
        if (take_cnt == 5'd4) src_next = take_sw[31:0];
        if (take_cnt == 5'd8) dst_next = take_sw[31:0];
        if (take_cnt >= 5'd12) begin
          if (!range_ok) begin
            err_fire = 1'b1;
            err_code = ERR_COPY_RANGE;
          end else begin
            res.has_main        = 1'b1;
            res.main.kind       = KIND_COPY;
            res.main.src_offset = src;
            res.main.dst_offset = dst;
            res.main.run_length = len;
            cmd_done            = 1'b1;
          end
        end else if (last_byte) begin
          err_fire = 1'b1;
          err_code = ERR_TRUNC_COPY;
        end
      end
      PH_ADDARGS: begin
        sw_next  = take_sw;
        cnt_next = take_cnt;
        if (take_cnt == 5'd4) dst_next = take_sw[31:0];
        if (take_cnt >= 5'd8) begin
          if (!range_ok) begin
            err_fire = 1'b1;
            err_code = ERR_ADD_RANGE;
          end else begin
            res.has_main        = 1'b1;
            res.main.kind       = KIND_ADD_HDR;
            res.main.dst_offset = dst;
            res.main.run_length = len;
            rem_next            = len;
            if (len == 32'd0) begin
              cmd_done = 1'b1;
            end else begin
              phase_next = PH_ADDDATA;
              cnt_next   = '0;
              sw_next    = '0;
              if (last_byte) begin
                err_fire = 1'b1;
                err_code = ERR_TRUNC_DATA;
              end
            end
          end
        end else if (last_byte) begin
          err_fire = 1'b1;
          err_code = ERR_TRUNC_ADD;
        end
      end
      PH_ADDDATA: begin
        res.has_main       = 1'b1;
        res.main.kind      = KIND_ADD_DAT;
        res.main.data_byte = byte_in;
        rem_next           = rem_dec;
        if (rem_dec == 32'd0) begin
          cmd_done = 1'b1;
        end else if (last_byte) begin
          err_fire = 1'b1;
          err_code = ERR_TRUNC_DATA;
        end
      end
      PH_DISCARD: begin
        if (last_byte) begin
          phase_next = PH_MAGIC;
          cnt_next   = '0;
          sw_next    = '0;
        end
      end
      default: begin
        phase_next = PH_MAGIC;
        cnt_next   = '0;
        sw_next    = '0;
      end
    endcase

    // command complete: back to opcode; on the last byte END is missing
    if (cmd_done) begin
      phase_next = PH_OPCODE;
      cnt_next   = '0;
      sw_next    = '0;
      if (last_byte) begin
        err_fire = 1'b1;
        err_code = ERR_MISSING_END;
      end
    end

    // error: drop bytes up to the last one, or restart if this is it
    if (err_fire) begin
      res.has_err  = 1'b1;
      res.err_code = err_code;
      phase_next   = last_byte ? PH_MAGIC : PH_DISCARD;
      cnt_next     = '0;
      sw_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_MAGIC;
      cnt    <= '0;
      sw     <= '0;
      vsize  <= '0;
      src    <= '0;
      dst    <= '0;
      rem    <= '0;
      hflags <= '0;
      ssum   <= '0;
    end else if (step) begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      sw     <= sw_next;
      vsize  <= vsize_next;
      src    <= src_next;
      dst    <= dst_next;
      rem    <= rem_next;
      hflags <= hflags_next;
      ssum   <= ssum_next;
    end
  end

endmodule
`default_nettype wire

[sv/delta_command_stream_parser.sv]
// Top level of the delta command stream parser: input register, parser, result queue.
// Takes one byte of a 32-bit delta file per transfer and sustains one byte per clock.
// A byte is first held in an input register; when the queue has room, the parser
// decodes it against its state and writes the zero, one or two records it causes
// into a four-entry result queue, whose head record drives the outputs. The input
// stalls only while the queue has fewer than two free entries, which happens only
// when the output side stalls. Records are header, copy, add header, add data, end
// ok and error; fields a kind does not use read as zero, and last_of_run marks the
// final record caused by a byte. After an error, bytes produce no records until the
// byte flagged last_byte, after which a new header is expected. CHECKSUM_BYTES sets
// the length of each header checksum.
`default_nettype none
module delta_command_stream_parser #(
  parameter int CHECKSUM_BYTES = dcsp_pkg::CHECKSUM_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  byte_in,
  input  wire         last_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  flags_byte,
  output logic [31:0] target_size,
  output logic [63:0] source_checksum,
  output logic [63:0] target_checksum,
  output logic [31:0] src_offset,
  output logic [31:0] dst_offset,
  output logic [31:0] run_length,
  output logic [7:0]  data_byte,
  output logic [3:0]  error_code,
  output logic        last_of_run
);
  import dcsp_pkg::*;

  // input register
  logic       in_v;
  logic [7:0] in_b;
  logic       in_l;

  // parser step happens when a byte waits and the queue has room for two records
  logic       step;
  logic       in_xfer;
  logic       out_xfer;

  parse_res_t res;
  rec_t       main_rec, err_rec, e0, e1;
  logic [1:0] push_n;

  // result queue
  rec_t           q [QDEPTH];
  logic [QPW-1:0] head, tail;
  logic [QCW-1:0] count, count_next;
  rec_t           head_rec;

  assign step     = in_v && (count <= QCW'(QDEPTH - 2));
  assign in_stall = in_v && !step;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_xfer) begin
      in_v <= 1'b1;
    end else if (step) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_b <= byte_in;
      in_l <= last_byte;
    end
  end

  dcsp_parse #(
    .CHECKSUM_BYTES(CHECKSUM_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .byte_in  (in_b),
    .last_byte(in_l),
    .res      (res)
  );

  // order: main record first, error record after it
  always_comb begin
    main_rec             = res.main;
    main_rec.last_of_run = !res.has_err;
    err_rec              = '0;
    err_rec.kind         = KIND_ERROR;
    err_rec.error_code   = res.err_code;
    err_rec.last_of_run  = 1'b1;
    e0                   = res.has_main ? main_rec : err_rec;
    e1                   = err_rec;
    if (step) begin
      push_n = {1'b0, res.has_main} + {1'b0, res.has_err};
    end else begin
      push_n = 2'd0;
    end
  end

  assign count_next = count + QCW'(push_n) - QCW'(out_xfer);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QPW'(out_xfer);
      tail  <= tail + QPW'(push_n);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q[tail] <= e0;
    if (push_n == 2'd2) q[tail + QPW'(1)] <= e1;
  end

  assign head_rec        = q[head];
  assign out_valid       = (count != '0);
  assign kind            = head_rec.kind;
  assign flags_byte      = head_rec.flags_byte;
  assign target_size     = head_rec.target_size;
  assign source_checksum = head_rec.source_checksum;
  assign target_checksum = head_rec.target_checksum;
  assign src_offset      = head_rec.src_offset;
  assign dst_offset      = head_rec.dst_offset;
  assign run_length      = head_rec.run_length;
  assign data_byte       = head_rec.data_byte;
  assign error_code      = head_rec.error_code;
  assign last_of_run     = head_rec.last_of_run;

  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("result queue overflow");

  // an error record always closes the run of its byte
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ERROR) |-> last_of_run)
    else $error("error record not marked last_of_run");

  // records other than errors carry no error code
  a_noerr_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_ERROR) |-> (error_code == ERR_NONE))
    else $error("error code on a non-error record");

  // a held byte that was not decoded is still held next cycle
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (in_v && !step) |=> (in_v && $stable(in_b) && $stable(in_l)))
    else $error("input register lost an undecoded byte");

  // a byte that causes two records needs both queue slots free of a pop race
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (count <= QCW'(QDEPTH - 2)))
    else $error("double push without room");

endmodule
`default_nettype wire
